// ===== rtl/vcdv_pkg.sv =====
// ----------------------------------------------------------------------------
// vcdv_pkg
// Shared types and constants of the identification number check block.
// ----------------------------------------------------------------------------
`default_nettype none

package vcdv_pkg;

  localparam int unsigned VinLen = 17;
  localparam int unsigned PosSat = 18;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_SHORT     = 3'd1,
    STATUS_LONG      = 3'd2,
    STATUS_IOQ       = 3'd3,
    STATUS_NON_ALNUM = 3'd4
  } status_e;

  // Per-identifier summary handed from the accumulator to the verdict stage
  typedef struct packed {
    status_e     status;
    logic [4:0]  bad_pos;
    logic [7:0]  bad_char;
    logic [9:0]  sum;
    logic [7:0]  check_char;
    logic [7:0]  year_char;
  } fin_t;

endpackage

`default_nettype wire

// ===== rtl/vin_check_digit_validator.sv =====
// ----------------------------------------------------------------------------
// vin_check_digit_validator
// Streams in one identifier character per beat; on the last character gives
// one verdict beat with length/character status, check digit and model year.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one character per beat in tdata, tlast on the final character.
//   m_axis: one verdict beat per identifier; no beat for other characters.
//   Characters may follow each other every cycle while s_axis_tready is high; one beat per cycle in.
//   Path: input register -> accumulator (summary register) -> verdict
//   (output register). A verdict reaches m_axis once its last character
//   has passed the input register, then the summary register, then the
//   output register.
//   Throughput is one character per cycle while s_axis_tready is high, set
//   by the weight-and-add update of the running sum.
//   When m_axis stalls, the output register holds its beat; the accumulator
//   and input register still take characters that give no verdict,
//   and s_axis_tready drops only when a last character must wait.
//   Reset clears all valid flags and the per-identifier state, so the next
//   character accepted is position one.
// ----------------------------------------------------------------------------
`default_nettype none

module vin_check_digit_validator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_code
  input  wire logic        s_axis_tlast,  // last_char
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] status, [7:3] bad_position, [15:8] bad_char, [16] check_ok,
  // [24:17] expected_check, [32:25] actual_check, [43:33] model_year
  output logic [47:0]      m_axis_tdata
);

  logic           in_valid_q;
  logic [7:0]     in_char_q;
  logic           in_last_q;
  logic           acc_ready;
  logic           fin_valid;
  logic           fin_ready;
  vcdv_pkg::fin_t fin;

  assign s_axis_tready = !in_valid_q || acc_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  vcdv_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_char_i   (in_char_q),
    .in_last_i   (in_last_q),
    .in_ready_o  (acc_ready),
    .fin_valid_o (fin_valid),
    .fin_o       (fin),
    .fin_ready_i (fin_ready)
  );

  vcdv_verdict u_verdict (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fin_valid_i (fin_valid),
    .fin_i       (fin),
    .fin_ready_o (fin_ready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_ready_i (m_axis_tready)
  );

endmodule

`default_nettype wire

// ===== rtl/vcdv_accum.sv =====
// ----------------------------------------------------------------------------
// vcdv_accum
// Per-character state: position, weighted sum, first error, captured check
// and year characters. Emits one summary record on the last character.
// ----------------------------------------------------------------------------
`default_nettype none

module vcdv_accum (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [7:0]    in_char_i,
  input  wire logic          in_last_i,
  output logic               in_ready_o,
  output logic               fin_valid_o,
  output vcdv_pkg::fin_t     fin_o,
  input  wire logic          fin_ready_i
);

  function automatic logic [3:0] translit(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= "0" && c <= "9")      v = 4'(c - "0");
    else if (c >= "A" && c <= "H") v = 4'(c - "A" + 8'd1);
    else if (c == "J")             v = 4'd1;
    else if (c == "K")             v = 4'd2;
    else if (c >= "L" && c <= "N") v = 4'(c - "L" + 8'd3);
    else if (c == "P")             v = 4'd7;
    else if (c == "R")             v = 4'd9;
    else if (c >= "S" && c <= "Z") v = 4'(c - "S" + 8'd2);
    return v;
  endfunction

  function automatic logic [3:0] weight(input logic [4:0] idx);
    logic [3:0] w;
    unique case (idx)
      5'd0:    w = 4'd8;
      5'd1:    w = 4'd7;
      5'd2:    w = 4'd6;
      5'd3:    w = 4'd5;
      5'd4:    w = 4'd4;
      5'd5:    w = 4'd3;
      5'd6:    w = 4'd2;
      5'd7:    w = 4'd10;
      5'd8:    w = 4'd0;
      5'd9:    w = 4'd9;
      5'd10:   w = 4'd8;
      5'd11:   w = 4'd7;
      5'd12:   w = 4'd6;
      5'd13:   w = 4'd5;
      5'd14:   w = 4'd4;
      5'd15:   w = 4'd3;
      5'd16:   w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  logic [4:0]        pos_q, pos_d;
  logic [9:0]        sum_q, sum_d;
  vcdv_pkg::status_e err_q, err_d;
  logic [4:0]        err_pos_q, err_pos_d;
  logic [7:0]        err_char_q, err_char_d;
  logic [7:0]        check_q, check_d;
  logic [7:0]        year_q, year_d;
  logic              fin_valid_q;
  vcdv_pkg::fin_t    fin_q, fin_d;

  logic [7:0] c_up;
  logic       alnum, ioq, in_range, advance;
  logic [7:0] prod;

  assign in_ready_o  = !in_last_i || !fin_valid_q || fin_ready_i;
  assign advance     = in_valid_i && in_ready_o;
  assign fin_valid_o = fin_valid_q;
  assign fin_o       = fin_q;

  always_comb begin
    c_up     = (in_char_i >= "a" && in_char_i <= "z") ? in_char_i - 8'd32 : in_char_i;
    alnum    = (c_up >= "0" && c_up <= "9") || (c_up >= "A" && c_up <= "Z");
    ioq      = (c_up == "I") || (c_up == "O") || (c_up == "Q");
    pos_d    = (pos_q < 5'(vcdv_pkg::PosSat)) ? pos_q + 5'd1 : pos_q;
    in_range = pos_d <= 5'(vcdv_pkg::VinLen);
    prod     = translit(c_up) * weight(pos_d - 5'd1);

    err_d      = err_q;
    err_pos_d  = err_pos_q;
    err_char_d = err_char_q;
    sum_d      = sum_q;
    check_d    = check_q;
    year_d     = year_q;
    if (in_range) begin
      if (err_q == vcdv_pkg::STATUS_OK && (ioq || !alnum)) begin
        err_d      = ioq ? vcdv_pkg::STATUS_IOQ : vcdv_pkg::STATUS_NON_ALNUM;
        err_pos_d  = pos_d;
        err_char_d = c_up;
      end
      if (alnum) sum_d = sum_q + 10'(prod);
      if (pos_d == 5'd9)  check_d = c_up;
      if (pos_d == 5'd10) year_d  = c_up;
    end

    fin_d            = '0;
    fin_d.sum        = sum_d;
    fin_d.check_char = check_d;
    fin_d.year_char  = year_d;
    priority if (pos_d < 5'(vcdv_pkg::VinLen)) begin
      fin_d.status = vcdv_pkg::STATUS_SHORT;
    end else if (pos_d > 5'(vcdv_pkg::VinLen)) begin
      fin_d.status = vcdv_pkg::STATUS_LONG;
    end else begin
      fin_d.status = err_d;
      if (err_d != vcdv_pkg::STATUS_OK) begin
        fin_d.bad_pos  = err_pos_d;
        fin_d.bad_char = err_char_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      sum_q      <= '0;
      err_q      <= vcdv_pkg::STATUS_OK;
      err_pos_q  <= '0;
      err_char_q <= '0;
      check_q    <= '0;
      year_q     <= '0;
    end else if (advance) begin
      if (in_last_i) begin
        // verdict given: back to a clean slate for the next identifier
        pos_q      <= '0;
        sum_q      <= '0;
        err_q      <= vcdv_pkg::STATUS_OK;
        err_pos_q  <= '0;
        err_char_q <= '0;
        check_q    <= '0;
        year_q     <= '0;
      end else begin
        pos_q      <= pos_d;
        sum_q      <= sum_d;
        err_q      <= err_d;
        err_pos_q  <= err_pos_d;
        err_char_q <= err_char_d;
        check_q    <= check_d;
        year_q     <= year_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (advance && in_last_i) begin
      fin_valid_q <= 1'b1;
    end else if (fin_ready_i) begin
      fin_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_i) fin_q <= fin_d;
  end

endmodule

`default_nettype wire

// ===== rtl/vcdv_verdict.sv =====
// ----------------------------------------------------------------------------
// vcdv_verdict
// Turns a summary record into the result beat: sum mod 11, check compare and
// model year lookup for OK status. Holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vcdv_verdict (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fin_valid_i,
  input  vcdv_pkg::fin_t      fin_i,
  output logic                fin_ready_o,
  output logic                out_valid_o,
  output logic [47:0]         out_data_o,
  input  wire logic           out_ready_i
);

  function automatic logic [10:0] year_of(input logic [7:0] c);
    logic [10:0] y;
    y = 11'd0;
    if (c >= "A" && c <= "H")      y = 11'd2010 + 11'(c - "A");
    else if (c >= "J" && c <= "N") y = 11'd2018 + 11'(c - "J");
    else if (c == "P")             y = 11'd2023;
    else if (c == "R")             y = 11'd2024;
    else if (c == "S" || c == "T") y = 11'd1995 + 11'(c - "S");
    else if (c >= "V" && c <= "Y") y = 11'd1997 + 11'(c - "V");
    else if (c >= "1" && c <= "9") y = 11'd2001 + 11'(c - "1");
    return y;
  endfunction

  logic        out_valid_q;
  logic [47:0] out_data_q, out_data_d;

  logic [18:0] recip;
  logic [6:0]  quot;
  logic [9:0]  q11;
  logic [4:0]  rem_raw;
  logic [3:0]  rem;
  logic [7:0]  exp_c, act_c;
  logic        ok;
  logic [10:0] year;
  logic        is_ok;

  assign fin_ready_o = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    // floor(s*372/4096) is floor(s/11) or one less for s < 1024
    recip   = 19'(fin_i.sum) * 19'd372;
    quot    = recip[18:12];
    q11     = {quot, 3'b000} + {1'b0, quot, 2'b00} - {3'b000, quot};
    rem_raw = 5'(fin_i.sum - q11);
    rem     = (rem_raw >= 5'd11) ? 4'(rem_raw - 5'd11) : rem_raw[3:0];
    is_ok   = fin_i.status == vcdv_pkg::STATUS_OK;
    exp_c   = '0;
    act_c   = '0;
    ok      = 1'b0;
    year    = '0;
    if (is_ok) begin
      exp_c = (rem == 4'd10) ? "X" : 8'h30 + 8'(rem);
      act_c = fin_i.check_char;
      ok    = act_c == exp_c;
      year  = year_of(fin_i.year_char);
    end
    out_data_d = {4'b0000, year, act_c, exp_c, ok, fin_i.bad_char, fin_i.bad_pos,
                  fin_i.status};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_ready_o) begin
      out_valid_q <= fin_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_ready_o && fin_valid_i) out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire
